### rtl/uqfs_pkg.sv
// Package for the URL query field splitter: parser phases, result codes,
// character constants and the result item type. No dependencies.
`default_nettype none

package uqfs_pkg;

  localparam logic [7:0] ChQuestion = 8'h3F;
  localparam logic [7:0] ChEquals   = 8'h3D;
  localparam logic [7:0] ChPercent  = 8'h25;
  localparam logic [7:0] ChPlus     = 8'h2B;
  localparam logic [7:0] ChAmp      = 8'h26;
  localparam logic [7:0] ChSpace    = 8'h20;

  localparam int unsigned QueueDepth = 4;

  typedef enum logic [4:0] {
    PhPreamble   = 5'b00001,
    PhToEq       = 5'b00010,
    PhFieldStart = 5'b00100,
    PhInField    = 5'b01000,
    PhTail       = 5'b10000
  } phase_e;

  typedef enum logic [1:0] {
    KindByte  = 2'd0,
    KindField = 2'd1,
    KindReq   = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StHex       = 2'd1,
    StEsc       = 2'd2,
    StMalformed = 2'd3
  } status_e;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data_byte;
    status_e    status;
    logic [7:0] field_total;
    logic       run_end;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok    = 1'b1;
    h.value = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.value = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.value = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

`default_nettype wire

### rtl/url_query_field_splitter.sv
// Top level of the URL query field splitter: byte parser and result queue.
// Depends on uqfs_pkg.
//
// It takes one request-line byte per cycle unless stalled and decodes the
// query part of an HTTP GET line into field bytes, field ends and a
// request-end item with status and field count. Each accepted byte updates
// the parser state in the cycle it is accepted and pushes zero, one or two
// result items into a four-entry result queue, which presents one item per
// cycle at the output unless stalled. Bytes with at most one result sustain
// one byte per cycle while out_stall_i is low; a final byte may cause two
// results. The input stalls while the queue holds more than two items.
`default_nettype none

module url_query_field_splitter (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       is_final_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      data_byte_o,
  output logic [1:0]      status_o,
  output logic [7:0]      field_total_o,
  output logic            run_end_o
);
  import uqfs_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  phase_e     phase_q, phase_d;
  logic [1:0] esc_left_q, esc_left_d;
  logic [7:0] esc_val_q, esc_val_d;
  status_e    err_q, err_d;
  logic [7:0] fields_q, fields_d;

  result_t    queue_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  logic    accept, pop;
  logic    has_byte_res;
  result_t byte_res, req_res;
  hex_t    hex;
  logic    end_fld;

  assign in_stall_o  = count_q > CntW'(QueueDepth - 2);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o && !out_stall_i;

  assign kind_o        = queue_q[rd_ptr_q].kind;
  assign data_byte_o   = queue_q[rd_ptr_q].data_byte;
  assign status_o      = queue_q[rd_ptr_q].status;
  assign field_total_o = queue_q[rd_ptr_q].field_total;
  assign run_end_o     = queue_q[rd_ptr_q].run_end;

  always_comb begin
    phase_d      = phase_q;
    esc_left_d   = esc_left_q;
    esc_val_d    = esc_val_q;
    err_d        = err_q;
    fields_d     = fields_q;
    has_byte_res = 1'b0;
    end_fld      = 1'b0;
    hex          = hex_decode(in_byte_i);
    byte_res.kind      = KindByte;
    byte_res.data_byte = in_byte_i;
    byte_res.status    = StOk;

    if (err_q == StOk) begin
      case (phase_q)
        PhPreamble: begin
          if (in_byte_i == ChQuestion) phase_d = PhToEq;
        end
        PhToEq: begin
          if (in_byte_i == ChEquals) phase_d = PhInField;
        end
        PhFieldStart, PhInField: begin
          if (esc_left_q != 2'd0) begin
            if (!hex.ok) begin
              err_d      = StHex;
              esc_left_d = 2'd0;
              esc_val_d  = 8'd0;
            end else begin
              esc_val_d  = {esc_val_q[3:0], hex.value};
              esc_left_d = esc_left_q - 2'd1;
              if (esc_left_q == 2'd1) begin
                has_byte_res       = 1'b1;
                byte_res.data_byte = {esc_val_q[3:0], hex.value};
              end
            end
          end else if (in_byte_i == ChPercent) begin
            esc_left_d = 2'd2;
            esc_val_d  = 8'd0;
          end else if (in_byte_i == ChPlus) begin
            has_byte_res       = 1'b1;
            byte_res.data_byte = ChSpace;
          end else if (in_byte_i == ChAmp) begin
            end_fld = 1'b1;
            phase_d = PhFieldStart;
          end else if (in_byte_i == ChSpace) begin
            end_fld = 1'b1;
            phase_d = PhTail;
          end else if (in_byte_i == ChEquals && phase_q == PhFieldStart) begin
            has_byte_res       = 1'b1;
            byte_res.data_byte = ChSpace;
            phase_d            = PhInField;
          end else begin
            has_byte_res = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (end_fld) begin
      has_byte_res       = 1'b1;
      byte_res.kind      = KindField;
      byte_res.data_byte = 8'd0;
      if (fields_q != 8'hFF) fields_d = fields_q + 8'd1;
    end
    byte_res.field_total = fields_d;
    byte_res.run_end     = !is_final_i;

    req_res.kind        = KindReq;
    req_res.data_byte   = 8'd0;
    req_res.field_total = fields_d;
    req_res.run_end     = 1'b1;
    if (err_d != StOk) begin
      req_res.status = StHex;
    end else if (esc_left_d != 2'd0) begin
      req_res.status = StEsc;
    end else if (phase_d != PhTail) begin
      req_res.status = StMalformed;
    end else begin
      req_res.status = StOk;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhPreamble;
      esc_left_q <= 2'd0;
      esc_val_q  <= 8'd0;
      err_q      <= StOk;
      fields_q   <= 8'd0;
    end else if (accept) begin
      if (is_final_i) begin
        phase_q    <= PhPreamble;
        esc_left_q <= 2'd0;
        esc_val_q  <= 8'd0;
        err_q      <= StOk;
        fields_q   <= 8'd0;
      end else begin
        phase_q    <= phase_d;
        esc_left_q <= esc_left_d;
        esc_val_q  <= esc_val_d;
        err_q      <= err_d;
        fields_q   <= fields_d;
      end
    end
  end

  logic [1:0]      n_push;
  logic [PtrW-1:0] wr_next;

  assign n_push  = accept ? ({1'b0, has_byte_res} + {1'b0, is_final_i}) : 2'd0;
  assign wr_next = wr_ptr_q + PtrW'(1);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (has_byte_res) begin
        queue_q[wr_ptr_q] <= byte_res;
        if (is_final_i) queue_q[wr_next] <= req_res;
      end else if (is_final_i) begin
        queue_q[wr_ptr_q] <= req_res;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(n_push);
      if (pop) rd_ptr_q <= rd_ptr_q + PtrW'(1);
      count_q <= count_q + CntW'(n_push) - CntW'(pop);
    end
  end

endmodule

`default_nettype wire
